// ===== hw/rtl/wsfb_pkg.sv =====
// Package for the WebSocket frame builder: field widths, command codes,
// configuration register indexes and length-encoding constants.
// Depends on nothing; imported by websocket_frame_builder.
`timescale 1ns / 1ps

package wsfb_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int FLEN_W          = 32;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int HDR_MAX         = 14;
  localparam int HDR_CNT_W       = 4;

  typedef logic [7:0]           byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FIN    = 3'd0;
  localparam cfg_idx_t CFG_RSV    = 3'd1;
  localparam cfg_idx_t CFG_OPCODE = 3'd2;
  localparam cfg_idx_t CFG_MASK   = 3'd3;
  localparam cfg_idx_t CFG_KEY    = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [6:0] LEN7_MID  = 7'd126;
  localparam logic [6:0] LEN7_LONG = 7'd127;
  localparam logic [6:0] LEN7_SHORT_MAX = 7'd125;

  localparam logic [3:0] OPCODE_TEXT = 4'h1;

endpackage

// ===== hw/rtl/websocket_frame_builder.sv =====
// Top level of the WebSocket frame builder: header sequencer, payload masking
// and the result register, all in one module.
// Depends on wsfb_pkg.
//
//  channel  direction  ports                                         handshake
//  in       input      in_cmd, in_frame_length, in_data_byte         in_valid / in_stall
//  out      output     out_byte, out_is_header, out_run_last,        out_valid / out_stall
//                      out_frame_end
//  cfg      input      cfg_index, cfg_wdata                          cfg_we
//
// Payload words may follow each other every cycle while the output is not stalled.
// A start word produces 2 to 14 header bytes, which leave the result register in
// turn; the header shift register holds the input off meanwhile.
// Reset is synchronous and active low; it restores the register defaults and
// closes any open frame. A stalled result holds, and the input is stalled only
// while the result register is full and stalled or a header run is pending.
`timescale 1ns / 1ps

module websocket_frame_builder #(
  parameter int LENGTH_BITS = wsfb_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [wsfb_pkg::FLEN_W-1:0]    in_frame_length,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_is_header,
  output logic                           out_run_last,
  output logic                           out_frame_end,
  input  logic                           cfg_we,
  input  logic [wsfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsfb_pkg::CFG_W-1:0]     cfg_wdata
);
  import wsfb_pkg::*;

  localparam int LEN_W = (LENGTH_BITS < FLEN_W) ? LENGTH_BITS : FLEN_W;

  logic              fin_r;
  logic [2:0]        rsv_r;
  logic [3:0]        opcode_r;
  logic              mask_en_r;
  logic [31:0]       mask_key_r;

  logic [LEN_W-1:0]  bytes_rem_r;
  logic [1:0]        key_phase_r;
  logic              frame_open_r;

  logic [HDR_MAX-2:0][7:0] hdr_r;
  logic [HDR_CNT_W-1:0]    hdr_cnt_r;
  logic                    hdr_zero_r;

  logic              out_valid_r;
  byte_t             out_byte_r;
  logic              out_hdr_r;
  logic              out_last_r;
  logic              out_end_r;

  logic              out_free;
  logic              in_accept;
  logic [LEN_W-1:0]  len;
  logic [63:0]       len_ext;
  logic              len_long;
  logic              len_mid;
  logic              len_zero;
  logic [HDR_MAX-1:0][7:0] hdr_bytes;
  logic [HDR_CNT_W-1:0]    hdr_rest;
  byte_t             key_byte;
  byte_t             pay_byte;
  logic [LEN_W-1:0]  bytes_rem_dec;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (hdr_cnt_r != '0) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign len      = in_frame_length[LEN_W-1:0];
  assign len_ext  = {{(64-LEN_W){1'b0}}, len};
  assign len_long = (len_ext[63:16] != '0);
  assign len_mid  = !len_long && (len_ext[15:0] > {9'd0, LEN7_SHORT_MAX});
  assign len_zero = (len == '0);

  always_comb begin
    hdr_bytes    = '0;
    hdr_bytes[0] = {fin_r, rsv_r, opcode_r};
    if (len_long) begin
      hdr_bytes[1] = {mask_en_r, LEN7_LONG};
      for (int i = 0; i < 8; i++) begin
        hdr_bytes[2+i] = len_ext[8*(7-i) +: 8];
      end
      for (int k = 0; k < 4; k++) begin
        hdr_bytes[10+k] = mask_key_r[8*(3-k) +: 8];
      end
      hdr_rest = mask_en_r ? 4'd13 : 4'd9;
    end else if (len_mid) begin
      hdr_bytes[1] = {mask_en_r, LEN7_MID};
      hdr_bytes[2] = len_ext[15:8];
      hdr_bytes[3] = len_ext[7:0];
      for (int k = 0; k < 4; k++) begin
        hdr_bytes[4+k] = mask_key_r[8*(3-k) +: 8];
      end
      hdr_rest = mask_en_r ? 4'd7 : 4'd3;
    end else begin
      hdr_bytes[1] = {mask_en_r, len_ext[6:0]};
      for (int k = 0; k < 4; k++) begin
        hdr_bytes[2+k] = mask_key_r[8*(3-k) +: 8];
      end
      hdr_rest = mask_en_r ? 4'd5 : 4'd1;
    end
  end

  always_comb begin
    case (key_phase_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  assign pay_byte      = in_data_byte ^ (mask_en_r ? key_byte : 8'h00);
  assign bytes_rem_dec = bytes_rem_r - {{(LEN_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r      <= 1'b1;
      rsv_r      <= 3'd0;
      opcode_r   <= OPCODE_TEXT;
      mask_en_r  <= 1'b0;
      mask_key_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIN:    fin_r      <= cfg_wdata[0];
        CFG_RSV:    rsv_r      <= cfg_wdata[2:0];
        CFG_OPCODE: opcode_r   <= cfg_wdata[3:0];
        CFG_MASK:   mask_en_r  <= cfg_wdata[0];
        CFG_KEY:    mask_key_r <= cfg_wdata[31:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_rem_r  <= '0;
      key_phase_r  <= 2'd0;
      frame_open_r <= 1'b0;
      hdr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (hdr_cnt_r != '0) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          out_byte_r  <= hdr_r[0];
          out_hdr_r   <= 1'b1;
          out_last_r  <= (hdr_cnt_r == 4'd1);
          out_end_r   <= (hdr_cnt_r == 4'd1) && hdr_zero_r;
          hdr_r       <= hdr_r >> 8;
          hdr_cnt_r   <= hdr_cnt_r - 4'd1;
        end
      end else if (in_accept && in_cmd == CMD_START) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= hdr_bytes[0];
        out_hdr_r    <= 1'b1;
        out_last_r   <= 1'b0;
        out_end_r    <= 1'b0;
        hdr_r        <= hdr_bytes[HDR_MAX-1:1];
        hdr_cnt_r    <= hdr_rest;
        hdr_zero_r   <= len_zero;
        bytes_rem_r  <= len;
        key_phase_r  <= 2'd0;
        frame_open_r <= !len_zero;
      end else if (in_accept && frame_open_r) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= pay_byte;
        out_hdr_r    <= 1'b0;
        out_last_r   <= 1'b1;
        out_end_r    <= (bytes_rem_dec == '0);
        bytes_rem_r  <= bytes_rem_dec;
        key_phase_r  <= key_phase_r + 2'd1;
        frame_open_r <= (bytes_rem_dec != '0);
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_is_header = out_hdr_r;
  assign out_run_last  = out_last_r;
  assign out_frame_end = out_end_r;

  a_open_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r == (bytes_rem_r != '0))
    else $error("Open frame flag disagrees with the remaining byte count.");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("Frame end flagged on a word that does not close its run.");

  a_start_opens_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_cmd == CMD_START |=> out_valid_r && out_hdr_r && !out_last_r
      && hdr_cnt_r != '0)
    else $error("Start word did not begin a header run.");

  a_run_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r != '0 |-> out_valid_r && out_hdr_r && !out_last_r)
    else $error("Pending header bytes without a header word in the result register.");

endmodule
